// ===== rtl/core/gvrop_pkg.sv =====
package gvrop_pkg;

   // access codes
   localparam logic [1:0] MODE_BYTE_READ  = 2'd0;
   localparam logic [1:0] MODE_BYTE_WRITE = 2'd1;
   localparam logic [1:0] MODE_WORD_READ  = 2'd2;
   localparam logic [1:0] MODE_WORD_WRITE = 2'd3;

   // write select codes (single-plane mode)
   localparam logic [1:0] WSEL_ROP     = 2'd0;
   localparam logic [1:0] WSEL_PATTERN = 2'd1;
   localparam logic [1:0] WSEL_CPU     = 2'd2;
   localparam logic [1:0] WSEL_KEEP    = 2'd3;

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE_PLANE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_SELECT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_PAGE0 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_PAGE1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROP_PAGE0     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROP_PAGE1     = 3'd5;
   localparam int CSR_DATA_W = 16;

   localparam int ADDR_W = 18;
   localparam int DATA_W = 16;
   localparam int WAIT_W = 4;

   localparam logic [WAIT_W-1:0] WAIT_READ_SP  = 4'd4;
   localparam logic [WAIT_W-1:0] WAIT_READ_MP  = 4'd7;
   localparam logic [WAIT_W-1:0] WAIT_WRITE_SP = 4'd1;
   localparam logic [WAIT_W-1:0] WAIT_WRITE_MP = 4'd4;

   typedef struct packed {
      logic        single_plane;
      logic [1:0]  write_select;
      logic [15:0] pattern_page0;
      logic [15:0] pattern_page1;
      logic [7:0]  rop_page0;
      logic [7:0]  rop_page1;
   } cfg_type;

   typedef struct packed {
      logic capture;   // latch request, read both byte lanes
      logic commit;    // write back lanes, load result
   } cmd_type;

   // 8-minterm logic on one byte lane; rop bit (p*4 + c*2 + m)
   function automatic logic [7:0] rop_byte(input logic [7:0] rop, input logic [7:0] p,
                                           input logic [7:0] c, input logic [7:0] m);
      logic [7:0] acc;
      logic [7:0] tp;
      logic [7:0] tc;
      logic [7:0] tm;
      acc = '0;
      for (int k = 0; k < 8; k++) begin
         tp = ((k & 4) != 0) ? p : ~p;
         tc = ((k & 2) != 0) ? c : ~c;
         tm = ((k & 1) != 0) ? m : ~m;
         if (rop[k]) begin
            acc = acc | (tp & tc & tm);
         end
      end
      return acc;
   endfunction

   // byte to store on one lane
   function automatic logic [7:0] store_byte(input cfg_type cfg, input logic [7:0] rop,
                                             input logic [7:0] p, input logic [7:0] c,
                                             input logic [7:0] m);
      logic [7:0] res;
      if (!cfg.single_plane) begin
         res = c;
      end else begin
         case (cfg.write_select)
            WSEL_ROP:     res = rop_byte(rop, p, c, m);
            WSEL_PATTERN: res = p;
            WSEL_CPU:     res = c;
            default:      res = m;
         endcase
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/gvrop_req_if.sv =====
interface gvrop_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [17:0] address;
   logic [15:0] write_data;

   modport source (output valid, output mode, output address, output write_data,
                   input ready);
   modport sink (input valid, input mode, input address, input write_data,
                 output ready);
endinterface

// ===== rtl/core/gvrop_rsp_if.sv =====
interface gvrop_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] read_data;
   logic [3:0]  wait_cycles;

   modport source (output valid, output read_data, output wait_cycles, input ready);
   modport sink (input valid, input read_data, input wait_cycles, output ready);
endinterface

// ===== rtl/core/gvrop_csr.sv =====
module gvrop_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [gvrop_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gvrop_pkg::CSR_DATA_W-1:0] csr_wdata,
   output gvrop_pkg::cfg_type             cfg
);

   gvrop_pkg::cfg_type cfg_ff;
   gvrop_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            gvrop_pkg::CSR_SINGLE_PLANE:  cfg_in.single_plane  = csr_wdata[0];
            gvrop_pkg::CSR_WRITE_SELECT:  cfg_in.write_select  = csr_wdata[1:0];
            gvrop_pkg::CSR_PATTERN_PAGE0: cfg_in.pattern_page0 = csr_wdata;
            gvrop_pkg::CSR_PATTERN_PAGE1: cfg_in.pattern_page1 = csr_wdata;
            gvrop_pkg::CSR_ROP_PAGE0:     cfg_in.rop_page0     = csr_wdata[7:0];
            gvrop_pkg::CSR_ROP_PAGE1:     cfg_in.rop_page1     = csr_wdata[7:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/gvrop_ctrl.sv =====
module gvrop_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output gvrop_pkg::cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_RMW  = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic accept;

   // the result slot is free in the cycle after an accept, so no check in S_RMW
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      state_in    = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = S_RMW;
            end
         end
         S_RMW: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/gvrop_dp.sv =====
module gvrop_dp #(
   parameter int VRAM_BYTES = 262144
) (
   input  logic                         clock,
   input  gvrop_pkg::cmd_type           cmd,
   input  gvrop_pkg::cfg_type           cfg,
   input  logic [1:0]                   req_mode,
   input  logic [gvrop_pkg::ADDR_W-1:0] req_address,
   input  logic [gvrop_pkg::DATA_W-1:0] req_write_data,
   output logic [gvrop_pkg::DATA_W-1:0] rsp_read_data,
   output logic [gvrop_pkg::WAIT_W-1:0] rsp_wait_cycles
);

   localparam int Rows = VRAM_BYTES / 2;
   localparam int RowW = $clog2(VRAM_BYTES) - 1;

   // even and odd byte lanes, one row per aligned word
   logic [7:0] mem_even [Rows];
   logic [7:0] mem_odd  [Rows];

   logic [1:0]      mode_ff;
   logic            odd_ff;
   logic [RowW-1:0] row_even_ff;
   logic [RowW-1:0] row_odd_ff;
   logic [15:0]     data_ff;
   logic [7:0]      old_even_ff;
   logic [7:0]      old_odd_ff;
   logic [15:0]     read_data_ff;
   logic [3:0]      wait_ff;

   logic [RowW-1:0] row_req;
   logic [RowW-1:0] row_even_in;

   logic [7:0]  cpu_even;
   logic [7:0]  cpu_odd;
   logic [7:0]  pat_even;
   logic [7:0]  pat_odd;
   logic [7:0]  rop_even;
   logic [7:0]  rop_odd;
   logic [7:0]  new_even;
   logic [7:0]  new_odd;
   logic        we_even;
   logic        we_odd;
   logic        is_write;
   logic [15:0] read_data_in;
   logic [3:0]  wait_in;

   // unaligned access: the even lane holds the byte at the next row
   assign row_req     = req_address[RowW:1];
   assign row_even_in = req_address[0] ? row_req + 1'b1 : row_req;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff     <= req_mode;
         odd_ff      <= req_address[0];
         row_even_ff <= row_even_in;
         row_odd_ff  <= row_req;
         data_ff     <= req_write_data;
         old_even_ff <= mem_even[row_even_in];
         old_odd_ff  <= mem_odd[row_req];
      end
   end

   always_comb begin
      cpu_even = odd_ff ? data_ff[15:8] : data_ff[7:0];
      cpu_odd  = odd_ff ? data_ff[7:0] : data_ff[15:8];
      // page is the top row bit, taken per lane
      pat_even = row_even_ff[RowW-1] ? cfg.pattern_page1[7:0]  : cfg.pattern_page0[7:0];
      pat_odd  = row_odd_ff[RowW-1]  ? cfg.pattern_page1[15:8] : cfg.pattern_page0[15:8];
      rop_even = row_even_ff[RowW-1] ? cfg.rop_page1 : cfg.rop_page0;
      rop_odd  = row_odd_ff[RowW-1]  ? cfg.rop_page1 : cfg.rop_page0;
      new_even = gvrop_pkg::store_byte(cfg, rop_even, pat_even, cpu_even, old_even_ff);
      new_odd  = gvrop_pkg::store_byte(cfg, rop_odd, pat_odd, cpu_odd, old_odd_ff);

      is_write = (mode_ff == gvrop_pkg::MODE_BYTE_WRITE) ||
                 (mode_ff == gvrop_pkg::MODE_WORD_WRITE);
      we_even  = ((mode_ff == gvrop_pkg::MODE_BYTE_WRITE) && !odd_ff) ||
                 (mode_ff == gvrop_pkg::MODE_WORD_WRITE);
      we_odd   = ((mode_ff == gvrop_pkg::MODE_BYTE_WRITE) && odd_ff) ||
                 (mode_ff == gvrop_pkg::MODE_WORD_WRITE);

      case (mode_ff)
         gvrop_pkg::MODE_BYTE_READ:
            read_data_in = {8'h00, (odd_ff ? old_odd_ff : old_even_ff)};
         gvrop_pkg::MODE_WORD_READ:
            read_data_in = odd_ff ? {old_even_ff, old_odd_ff} : {old_odd_ff, old_even_ff};
         default:
            read_data_in = '0;
      endcase

      if (!is_write) begin
         wait_in = cfg.single_plane ? gvrop_pkg::WAIT_READ_SP : gvrop_pkg::WAIT_READ_MP;
      end else begin
         wait_in = cfg.single_plane ? gvrop_pkg::WAIT_WRITE_SP : gvrop_pkg::WAIT_WRITE_MP;
         // unaligned word write is charged as two byte writes
         if ((mode_ff == gvrop_pkg::MODE_WORD_WRITE) && odd_ff) begin
            wait_in = {wait_in[2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && we_even) begin
         mem_even[row_even_ff] <= new_even;
      end
      if (cmd.commit && we_odd) begin
         mem_odd[row_odd_ff] <= new_odd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         read_data_ff <= read_data_in;
         wait_ff      <= wait_in;
      end
   end

   assign rsp_read_data   = read_data_ff;
   assign rsp_wait_cycles = wait_ff;

endmodule

// ===== rtl/core/graphics_vram_raster_op_write_unit.sv =====
// Graphics memory with a raster-op unit on the write path.
// req_bus carries one CPU access (mode, address, write_data); rsp_bus returns
// one item per access with read_data (zero for writes) and wait_cycles.
// The csr_ port writes the mode, write select, per-page pattern and per-page
// minterm registers; write it only while no access is in flight.
// Timing: when an access is accepted, the memory row is read at that edge, and
// the next cycle computes and writes back the bytes and loads the result
// register, which then offers the result. A new access is taken only after
// that read-then-write pass over the single-ported byte lanes has finished.
// An unaligned word touches both lanes in that same pass.
// Reset clears the configuration registers and the control state; the datapath
// registers and memory contents stay undefined until written and need no clearing pass.
// When the receiver stalls, the result holds in its register and no further
// access is taken until the pending result is taken; the next access may be
// taken at that same edge.
module graphics_vram_raster_op_write_unit #(
   parameter int VRAM_BYTES = 262144
) (
   input  logic                             clock,
   input  logic                             reset,
   gvrop_req_if.sink                        req_bus,
   gvrop_rsp_if.source                      rsp_bus,
   input  logic                             csr_we,
   input  logic [gvrop_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gvrop_pkg::CSR_DATA_W-1:0] csr_wdata
);

   gvrop_pkg::cfg_type cfg;
   gvrop_pkg::cmd_type cmd;

   gvrop_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gvrop_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   gvrop_dp #(
      .VRAM_BYTES (VRAM_BYTES)
   ) u_dp (
      .clock           (clock),
      .cmd             (cmd),
      .cfg             (cfg),
      .req_mode        (req_bus.mode),
      .req_address     (req_bus.address),
      .req_write_data  (req_bus.write_data),
      .rsp_read_data   (rsp_bus.read_data),
      .rsp_wait_cycles (rsp_bus.wait_cycles)
   );

endmodule
